// ----- rtl/core/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the buddy allocator RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic property, sampled on clk, disabled while reset is active.
`define BBA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Same-cycle implication.
`define BBA_ASSERT_IMP(lbl, ante, cons, msg) \
	`BBA_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication.
`define BBA_ASSERT_NXT(lbl, ante, cons, msg) \
	`BBA_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ----- rtl/core/bba_pkg.sv -----
// ---------------------------------------------------------------------------
// bba_pkg
// Types, constants and helper functions of the buddy block allocator.
// ---------------------------------------------------------------------------
package bba_pkg;

	localparam int DEF_BLOCKS          = 1024;
	localparam int DEF_MIN_BLOCK_BYTES = 1024;
	localparam int DEF_LEVELS          = 11;

	localparam int WORD_BITS  = 64;
	localparam int WORD_IDX_W = 6;

	localparam logic [31:0] BASE_RESET = 32'h0010_0000;

	localparam logic CMD_ALLOC = 1'b0;

	typedef enum logic [1:0] {
		STAT_OK,
		STAT_TOO_LARGE,
		STAT_NO_SPACE,
		STAT_BAD_ADDR
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_TBL_RD,
		S_TBL_CHK,
		S_MRG_RD,
		S_MRG_WR,
		S_FREE_END,
		S_SRCH_LVL,
		S_SRCH_RD,
		S_SRCH_CHK,
		S_BIT_RD,
		S_BIT_WR,
		S_ALLOC_END,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic    clr_en;
		logic    capture;
		logic    div_init;
		logic    tbl_rd;
		logic    tbl_free;
		logic    mrg_rd;
		logic    mrg_wr;
		logic    lvl_init;
		logic    lvl_inc;
		logic    wi_clr;
		logic    wi_inc;
		logic    srch_rd;
		logic    srch_hit;
		logic    bit_rd;
		logic    bit_wr;
		logic    split_step;
		logic    alloc_end;
		logic    free_end;
		logic    st_load;
		status_t st_code;
		logic    out_load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic is_alloc;
		logic too_big;
		logic overflow;
		logic bad_free;
		logic tbl_valid;
		logic off_oob;
		logic mrg_buddy;
		logic lvl_top;
		logic lvl_end;
		logic cnt_zero;
		logic wi_end;
		logic word_hit;
		logic at_want;
		logic out_free;
	} sts_t;

	// First bitmap word of a level; every level starts on a word boundary.
	function automatic int word_base(input int blocks, input int lvl);
		int b;
		b = 0;
		for (int k = 0; k < lvl; k++) begin
			b = b + (((blocks >> k) + WORD_BITS - 1) >> WORD_IDX_W);
		end
		return b;
	endfunction

endpackage

// ----- rtl/core/bba_ctrl.sv -----
// ---------------------------------------------------------------------------
// bba_ctrl
// Sequencer of the buddy allocator: clearing pass, decode, search, split,
// coalesce and result hand-off.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bba_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  bba_pkg::sts_t sts,
	output bba_pkg::cmd_t cmd
);
	import bba_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.st_code = STAT_OK;
		in_stall = (state_q != S_IDLE);
		case (state_q)
			S_CLEAR: begin
				cmd.clr_en = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.is_alloc) begin
					if (sts.too_big) begin
						cmd.st_load = 1'b1;
						cmd.st_code = STAT_TOO_LARGE;
						state_d     = S_FINISH;
					end else if (sts.overflow) begin
						cmd.st_load = 1'b1;
						cmd.st_code = STAT_NO_SPACE;
						state_d     = S_FINISH;
					end else begin
						cmd.lvl_init = 1'b1;
						state_d      = S_SRCH_LVL;
					end
				end else if (sts.bad_free) begin
					cmd.st_load = 1'b1;
					cmd.st_code = STAT_BAD_ADDR;
					state_d     = S_FINISH;
				end else begin
					cmd.div_init = 1'b1;
					state_d      = S_TBL_RD;
				end
			end
			S_TBL_RD: begin
				cmd.tbl_rd = 1'b1;
				state_d    = S_TBL_CHK;
			end
			S_TBL_CHK: begin
				if (!sts.tbl_valid) begin
					cmd.st_load = 1'b1;
					cmd.st_code = STAT_BAD_ADDR;
					state_d     = S_FINISH;
				end else begin
					cmd.tbl_free = 1'b1;
					state_d      = S_MRG_RD;
				end
			end
			S_MRG_RD: begin
				if (sts.off_oob) begin
					state_d = S_FREE_END;
				end else begin
					cmd.mrg_rd = 1'b1;
					state_d    = S_MRG_WR;
				end
			end
			S_MRG_WR: begin
				cmd.mrg_wr = 1'b1;
				if (sts.mrg_buddy && !sts.lvl_top) begin
					state_d = S_MRG_RD;
				end else begin
					state_d = S_FREE_END;
				end
			end
			S_FREE_END: begin
				cmd.free_end = 1'b1;
				cmd.st_load  = 1'b1;
				cmd.st_code  = STAT_OK;
				state_d      = S_FINISH;
			end
			S_SRCH_LVL: begin
				if (sts.lvl_end) begin
					cmd.st_load = 1'b1;
					cmd.st_code = STAT_NO_SPACE;
					state_d     = S_FINISH;
				end else if (sts.cnt_zero) begin
					cmd.lvl_inc = 1'b1;
				end else begin
					cmd.wi_clr = 1'b1;
					state_d    = S_SRCH_RD;
				end
			end
			S_SRCH_RD: begin
				if (sts.wi_end) begin
					cmd.lvl_inc = 1'b1;
					state_d     = S_SRCH_LVL;
				end else begin
					cmd.srch_rd = 1'b1;
					state_d     = S_SRCH_CHK;
				end
			end
			S_SRCH_CHK: begin
				if (sts.word_hit) begin
					cmd.srch_hit = 1'b1;
					state_d      = S_BIT_RD;
				end else begin
					cmd.wi_inc = 1'b1;
					state_d    = S_SRCH_RD;
				end
			end
			S_BIT_RD: begin
				cmd.bit_rd = 1'b1;
				state_d    = S_BIT_WR;
			end
			S_BIT_WR: begin
				cmd.bit_wr = 1'b1;
				if (sts.at_want) begin
					state_d = S_ALLOC_END;
				end else begin
					cmd.split_step = 1'b1;
					state_d        = S_BIT_RD;
				end
			end
			S_ALLOC_END: begin
				cmd.alloc_end = 1'b1;
				cmd.st_load   = 1'b1;
				cmd.st_code   = STAT_OK;
				state_d       = S_FINISH;
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	`BBA_ASSERT_NXT(a_accept_decodes, in_valid && !in_stall, state_q == S_DECODE, "accepted request did not reach decode")
	`BBA_ASSERT_IMP(a_load_when_free, cmd.out_load, sts.out_free, "result loaded over a pending result")

endmodule

// ----- rtl/core/bba_dp.sv -----
// ---------------------------------------------------------------------------
// bba_dp
// Datapath of the buddy allocator: free bitmap words, level table, free
// counts, slot decode, used-byte total and result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bba_dp #(
	parameter int BLOCKS          = bba_pkg::DEF_BLOCKS,
	parameter int MIN_BLOCK_BYTES = bba_pkg::DEF_MIN_BLOCK_BYTES,
	parameter int LEVELS          = bba_pkg::DEF_LEVELS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [31:0]   base_address,
	input  logic          command,
	input  logic [31:0]   alloc_size,
	input  logic [31:0]   block_address,
	input  bba_pkg::cmd_t cmd,
	output bba_pkg::sts_t sts,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [1:0]    status,
	output logic [31:0]   result_address,
	output logic [20:0]   used_bytes
);
	import bba_pkg::*;

	localparam int BLK_W    = $clog2(BLOCKS);
	localparam int LV_W     = $clog2(LEVELS + 1);
	localparam int CNT_W    = BLK_W + 1;
	localparam int NWORDS   = word_base(BLOCKS, LEVELS);
	localparam int WA_W     = $clog2(NWORDS);
	localparam int TOP_LVL  = BLK_W;
	localparam int TOP_WORD = word_base(BLOCKS, TOP_LVL);
	localparam logic [63:0] POOL = 64'(BLOCKS) * 64'(MIN_BLOCK_BYTES);
	localparam int USED_W   = $clog2(POOL + 64'd1);
	localparam int MB_SH    = $clog2(MIN_BLOCK_BYTES);
	localparam int TE_W     = LV_W + 1;

	logic [WA_W:0] wbase [LEVELS+1];
	logic [WA_W:0] wnext [LEVELS+1];

	for (genvar g = 0; g <= LEVELS; g++) begin : g_wbase
		assign wbase[g] = (WA_W + 1)'(word_base(BLOCKS, g));
		assign wnext[g] = (WA_W + 1)'(word_base(BLOCKS, g + 1));
	end

	logic [WORD_BITS-1:0] bm_mem [NWORDS];
	logic [TE_W-1:0]      tbl_mem [BLOCKS];
	logic [WORD_BITS-1:0] rdata_q;
	logic [TE_W-1:0]      tbl_rdata_q;

	logic              cmd_q;
	logic [31:0]       size_q;
	logic [31:0]       addr_q;
	logic [LV_W-1:0]   want_q;
	logic [LV_W-1:0]   lvl_q;
	logic [BLK_W-1:0]  off_q;
	logic [BLK_W-1:0]  wi_q;
	logic              setv_q;
	logic [BLK_W-1:0]  slot_q;
	logic [CNT_W-1:0]  cnt_q [LEVELS];
	logic [USED_W-1:0] used_q;
	logic [BLK_W-1:0]  clr_q;
	status_t           status_q;
	logic [31:0]       res_q;
	logic              out_valid_q;
	status_t           out_status_q;
	logic [31:0]       out_addr_q;
	logic [USED_W-1:0] out_used_q;

	logic [LV_W-1:0]      want_c;
	logic                 fit_c;
	logic [63:0]          aligned_c;
	logic [31:0]          rel_c;
	logic [CNT_W-1:0]     cnt_sel;
	logic [CNT_W-1:0]     blk_lvl;
	logic [BLK_W-1:0]     tgt_c;
	logic [BLK_W+5:0]     offx;
	logic [BLK_W-1:0]     widx;
	logic [5:0]           bpos;
	logic [WA_W-1:0]      tgt_addr;
	logic [WA_W-1:0]      srch_addr;
	logic                 ob;
	logic                 bb;
	logic [WORD_BITS-1:0] mrg_word;
	logic [WORD_BITS-1:0] bit_word;
	logic [5:0]           pe;
	logic [BLK_W-1:0]     aslot;
	logic [BLK_W+16:0]    rel_a;
	logic [63:0]          bsize_c;

	always_comb begin
		want_c = '0;
		fit_c  = 1'b0;
		for (int l = LEVELS - 1; l >= 0; l--) begin
			if (64'(size_q) <= (64'(MIN_BLOCK_BYTES) << l)) begin
				want_c = LV_W'(l);
				fit_c  = 1'b1;
			end
		end
	end

	always_comb begin
		cnt_sel = '0;
		for (int g = 0; g < LEVELS; g++) begin
			if (32'(lvl_q) == g) begin
				cnt_sel = cnt_q[g];
			end
		end
	end

	always_comb begin
		pe = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (rdata_q[i]) begin
				pe = 6'(i);
			end
		end
	end

	assign aligned_c = 64'(MIN_BLOCK_BYTES) << want_c;
	assign rel_c     = addr_q - base_address;
	assign blk_lvl   = CNT_W'(BLOCKS) >> lvl_q;
	assign tgt_c     = setv_q ? (off_q | BLK_W'(1)) : off_q;
	assign offx      = {6'd0, tgt_c};
	assign widx      = offx[BLK_W+5:6];
	assign bpos      = offx[5:0];
	assign tgt_addr  = WA_W'(32'(wbase[lvl_q]) + 32'(widx));
	assign srch_addr = WA_W'(32'(wbase[lvl_q]) + 32'(wi_q));
	assign ob        = rdata_q[bpos];
	assign bb        = ({1'b0, off_q ^ BLK_W'(1)} < blk_lvl) && rdata_q[bpos ^ 6'd1];
	assign aslot     = off_q << want_q;
	assign rel_a     = {17'd0, aslot} * {{BLK_W{1'b0}}, 17'(MIN_BLOCK_BYTES)};
	assign bsize_c   = 64'(MIN_BLOCK_BYTES) << want_q;

	always_comb begin
		mrg_word = rdata_q;
		if (bb) begin
			mrg_word[bpos]         = 1'b0;
			mrg_word[bpos ^ 6'd1]  = 1'b0;
		end else begin
			mrg_word[bpos] = 1'b1;
		end
		bit_word       = rdata_q;
		bit_word[bpos] = setv_q;
	end

	always_comb begin
		sts.clr_last  = (clr_q == BLK_W'(BLOCKS - 1));
		sts.is_alloc  = (cmd_q == CMD_ALLOC);
		sts.too_big   = !fit_c;
		sts.overflow  = (64'(used_q) + aligned_c) > POOL;
		sts.bad_free  = (addr_q == 32'd0) || (64'(rel_c) >= POOL);
		sts.tbl_valid = tbl_rdata_q[LV_W];
		sts.off_oob   = {1'b0, off_q} >= blk_lvl;
		sts.mrg_buddy = bb;
		sts.lvl_top   = (32'(lvl_q) == LEVELS - 1);
		sts.lvl_end   = (32'(lvl_q) >= LEVELS);
		sts.cnt_zero  = (cnt_sel == '0);
		sts.wi_end    = (32'(wbase[lvl_q]) + 32'(wi_q)) >= 32'(wnext[lvl_q]);
		sts.word_hit  = (rdata_q != '0);
		sts.at_want   = (lvl_q == want_q);
		sts.out_free  = !out_valid_q || !out_stall;
	end

	always_ff @(posedge clk) begin
		if (cmd.srch_rd) begin
			rdata_q <= bm_mem[srch_addr];
		end else if (cmd.mrg_rd || cmd.bit_rd) begin
			rdata_q <= bm_mem[tgt_addr];
		end
		if (cmd.clr_en && (32'(clr_q) < NWORDS)) begin
			bm_mem[WA_W'(clr_q)] <= ((TOP_LVL < LEVELS) && (32'(clr_q) == TOP_WORD)) ?
				WORD_BITS'(1) : '0;
		end else if (cmd.mrg_wr) begin
			bm_mem[tgt_addr] <= mrg_word;
		end else if (cmd.bit_wr) begin
			bm_mem[tgt_addr] <= bit_word;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tbl_rd) begin
			tbl_rdata_q <= tbl_mem[slot_q];
		end
		if (cmd.clr_en) begin
			tbl_mem[clr_q] <= '0;
		end else if (cmd.tbl_free) begin
			tbl_mem[slot_q] <= '0;
		end else if (cmd.alloc_end) begin
			tbl_mem[aslot] <= {1'b1, want_q};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q  <= command;
			size_q <= alloc_size;
			addr_q <= block_address;
		end
		if (cmd.lvl_init) begin
			want_q <= want_c;
			lvl_q  <= want_c;
		end else if (cmd.tbl_free) begin
			want_q <= tbl_rdata_q[LV_W-1:0];
			lvl_q  <= tbl_rdata_q[LV_W-1:0];
		end else if (cmd.lvl_inc || (cmd.mrg_wr && bb)) begin
			lvl_q <= lvl_q + LV_W'(1);
		end else if (cmd.split_step) begin
			lvl_q <= lvl_q - LV_W'(1);
		end
		if (cmd.tbl_free) begin
			off_q  <= slot_q >> tbl_rdata_q[LV_W-1:0];
			setv_q <= 1'b0;
		end else if (cmd.mrg_wr && bb) begin
			off_q <= off_q >> 1;
		end else if (cmd.srch_hit) begin
			off_q  <= BLK_W'((32'(wi_q) << WORD_IDX_W) | 32'(pe));
			setv_q <= 1'b0;
		end else if (cmd.split_step) begin
			off_q  <= off_q << 1;
			setv_q <= 1'b1;
		end
		if (cmd.wi_clr) begin
			wi_q <= '0;
		end else if (cmd.wi_inc) begin
			wi_q <= wi_q + BLK_W'(1);
		end
		if (cmd.div_init) begin
			slot_q <= BLK_W'(rel_c >> MB_SH);
		end
		if (cmd.st_load) begin
			status_q <= cmd.st_code;
			res_q    <= cmd.alloc_end ? (base_address + 32'(rel_a)) : 32'd0;
		end
		if (cmd.out_load) begin
			out_status_q <= status_q;
			out_addr_q   <= res_q;
			out_used_q   <= used_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			used_q      <= '0;
			out_valid_q <= 1'b0;
			for (int g = 0; g < LEVELS; g++) begin
				cnt_q[g] <= (g == TOP_LVL) ? CNT_W'(1) : '0;
			end
		end else begin
			if (cmd.clr_en && !sts.clr_last) begin
				clr_q <= clr_q + BLK_W'(1);
			end
			for (int g = 0; g < LEVELS; g++) begin
				if (32'(lvl_q) == g) begin
					if (cmd.mrg_wr) begin
						cnt_q[g] <= cnt_q[g] + CNT_W'(!ob) - (bb ? CNT_W'(2) : '0);
					end else if (cmd.bit_wr) begin
						if (setv_q && !ob) begin
							cnt_q[g] <= cnt_q[g] + CNT_W'(1);
						end else if (!setv_q && ob) begin
							cnt_q[g] <= cnt_q[g] - CNT_W'(1);
						end
					end
				end
			end
			if (cmd.alloc_end) begin
				used_q <= USED_W'(64'(used_q) + aligned_c);
			end else if (cmd.free_end) begin
				used_q <= (64'(used_q) >= bsize_c) ? USED_W'(64'(used_q) - bsize_c) : '0;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign result_address = out_addr_q;
	assign used_bytes     = 21'(out_used_q);

	`BBA_ASSERT_IMP(a_split_src_free, cmd.bit_wr && !setv_q, ob, "found block was not free")
	`BBA_ASSERT(a_used_in_pool, 64'(used_q) <= POOL, "used bytes exceed pool")
	`BBA_ASSERT_IMP(a_no_req_in_clear, cmd.clr_en, !out_valid_q && !cmd.capture, "activity during clearing pass")

endmodule

// ----- rtl/core/buddy_block_allocator.sv -----
// ---------------------------------------------------------------------------
// buddy_block_allocator
// Buddy allocator over a power-of-two pool of minimum blocks, with a free
// bitmap and free count per level and a level table per minimum block.
//
//   Channel   Signals                                         Direction
//   request   in_valid, in_stall, command, alloc_size,        in
//             block_address
//   result    out_valid, out_stall, status, result_address,   out
//             used_bytes
//   config    psel, penable, pwrite, paddr, pwdata, prdata,   in/out
//             pready
//
// After reset a clearing pass initializes the bitmap and level table
// memories; in_stall stays high during it.
// One request is handled at a time: a free reads the level table, then
// coalesces buddies level by level; an allocate skips empty levels, scans
// bitmap words for a free block and splits it down to the wanted level.
// Bitmap and level table reads are registered.
// A stalled result waits in the output register; the next request is taken
// and processed meanwhile and holds in S_FINISH until the result leaves.
// ---------------------------------------------------------------------------
module buddy_block_allocator #(
	parameter int BLOCKS          = bba_pkg::DEF_BLOCKS,
	parameter int MIN_BLOCK_BYTES = bba_pkg::DEF_MIN_BLOCK_BYTES,
	parameter int LEVELS          = bba_pkg::DEF_LEVELS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [31:0] alloc_size,
	input  logic [31:0] block_address,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] result_address,
	output logic [20:0] used_bytes
);
	import bba_pkg::*;

	logic [31:0] base_q;
	logic        reg_hit;
	cmd_t        cmd;
	sts_t        sts;

	assign pready  = 1'b1;
	assign reg_hit = (paddr == 3'd0);
	assign prdata  = reg_hit ? base_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RESET;
		end else if (psel && penable && pwrite && reg_hit) begin
			base_q <= pwdata;
		end
	end

	bba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	bba_dp #(
		.BLOCKS          (BLOCKS),
		.MIN_BLOCK_BYTES (MIN_BLOCK_BYTES),
		.LEVELS          (LEVELS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.base_address   (base_q),
		.command        (command),
		.alloc_size     (alloc_size),
		.block_address  (block_address),
		.cmd            (cmd),
		.sts            (sts),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.result_address (result_address),
		.used_bytes     (used_bytes)
	);

endmodule

// ----- verif/bba_checker.sv -----
// ----------------------------------------------------------------------------
// Buddy allocator checker
// Watches the request, result and configuration ports of the buddy block
// allocator. It keeps its own copy of the free bitmaps, the free counts, the
// level table and the used byte total, works out the result of every
// accepted request and compares it field by field with the block's results.
// ----------------------------------------------------------------------------
module bba_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        command,
	input  logic [31:0] alloc_size,
	input  logic [31:0] block_address,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  status,
	input  logic [31:0] result_address,
	input  logic [20:0] used_bytes,
	output int          errors,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import bba_pkg::*;

	localparam int NBLK = DEF_BLOCKS;
	localparam int MINB = DEF_MIN_BLOCK_BYTES;
	localparam int NLVL = DEF_LEVELS;
	localparam longint POOL_BYTES = longint'(NBLK) * MINB;
	localparam logic [2:0] ADDR_BASE = 3'd0;
	localparam logic [3:0] LVL_NONE = 4'd15;

	typedef struct {
		status_t     st;
		logic [31:0] addr;
		logic [20:0] used;
	} outcome_t;

	outcome_t    outcomes_due[$];
	bit          free_map[NLVL][NBLK];
	int unsigned free_cnt[NLVL];
	logic [3:0]  size_level[NBLK];
	longint      bytes_in_use;
	logic [31:0] pool_base;

	assign pending = outcomes_due.size();

	function automatic void mark(int lvl, int unsigned idx, bit is_free);
		if (idx >= (NBLK >> lvl))
			return;
		if (is_free && !free_map[lvl][idx])
			free_cnt[lvl]++;
		else if (!is_free && free_map[lvl][idx])
			free_cnt[lvl]--;
		free_map[lvl][idx] = is_free;
	endfunction

	function automatic bit is_free_at(int lvl, int unsigned idx);
		if (idx >= (NBLK >> lvl))
			return 1'b0;
		return free_map[lvl][idx];
	endfunction

	function automatic void clear_pool();
		for (int l = 0; l < NLVL; l++) begin
			free_cnt[l] = 0;
			for (int i = 0; i < NBLK; i++)
				free_map[l][i] = 1'b0;
		end
		for (int i = 0; i < NBLK; i++)
			size_level[i] = LVL_NONE;
		for (int l = 0; l < NLVL; l++) begin
			if (((NBLK >> l) & 1) != 0)
				mark(l, (NBLK >> l) - 1, 1'b1);
		end
		bytes_in_use = 0;
		pool_base = BASE_RESET;
	endfunction

	function automatic outcome_t take_block(logic [31:0] size);
		outcome_t    r;
		int          want;
		int          found;
		int unsigned off;
		longint      aligned;
		longint      rel;
		want = -1;
		found = -1;
		off = 0;
		r.addr = '0;
		for (int l = 0; l < NLVL; l++) begin
			if (want < 0 && longint'(size) <= (longint'(MINB) << l))
				want = l;
		end
		if (want < 0) begin
			r.st = STAT_TOO_LARGE;
		end else begin
			aligned = longint'(MINB) << want;
			if (bytes_in_use + aligned > POOL_BYTES) begin
				r.st = STAT_NO_SPACE;
			end else begin
				for (int l = want; l < NLVL; l++) begin
					if (found < 0 && free_cnt[l] != 0) begin
						for (int i = 0; i < (NBLK >> l); i++) begin
							if (found < 0 && free_map[l][i]) begin
								found = l;
								off = i;
							end
						end
					end
				end
				if (found < 0) begin
					r.st = STAT_NO_SPACE;
				end else begin
					mark(found, off, 1'b0);
					for (int l = found - 1; l >= want; l--) begin
						mark(l, off * 2 + 1, 1'b1);
						off = off * 2;
					end
					rel = aligned * off;
					size_level[rel / MINB] = want[3:0];
					bytes_in_use += aligned;
					r.st = STAT_OK;
					r.addr = pool_base + rel[31:0];
				end
			end
		end
		r.used = bytes_in_use[20:0];
		return r;
	endfunction

	function automatic outcome_t give_back(logic [31:0] addr);
		outcome_t    r;
		logic [31:0] rel;
		int          slot;
		int          lvl;
		int unsigned off;
		longint      bsize;
		r.st = STAT_BAD_ADDR;
		r.addr = '0;
		rel = addr - pool_base;
		if (addr != 0 && longint'(rel) < POOL_BYTES) begin
			slot = rel / MINB;
			if (size_level[slot] < NLVL) begin
				lvl = size_level[slot];
				size_level[slot] = LVL_NONE;
				bsize = longint'(MINB) << lvl;
				off = longint'(rel) / bsize;
				for (int l = lvl; l < NLVL; l++) begin
					mark(l, off, 1'b1);
					if (!is_free_at(l, off ^ 1))
						break;
					mark(l, off ^ 1, 1'b0);
					mark(l, off, 1'b0);
					off = off >> 1;
				end
				bytes_in_use = (bytes_in_use >= bsize) ? bytes_in_use - bsize : 0;
				r.st = STAT_OK;
			end
		end
		r.used = bytes_in_use[20:0];
		return r;
	endfunction

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		$display("%0t: result %s is 0x%0h, expected 0x%0h", $realtime, field, got, want);
		errors++;
	endtask

	initial errors = 0;

	always @(posedge clk or negedge arst_n) begin
		outcome_t e;
		if (!arst_n) begin
			clear_pool();
			outcomes_due.delete();
		end else begin
			if (psel && penable && pwrite && pready && paddr == ADDR_BASE)
				pool_base = pwdata;
			if (in_valid && !in_stall) begin
				if (command == CMD_ALLOC)
					outcomes_due.push_back(take_block(alloc_size));
				else
					outcomes_due.push_back(give_back(block_address));
			end
			if (out_valid && !out_stall) begin
				if (outcomes_due.size() == 0) begin
					$display("%0t: result with no request outstanding", $realtime);
					errors++;
				end else begin
					e = outcomes_due.pop_front();
					if (status != e.st)
						report_mismatch("status", status, e.st);
					if (result_address != e.addr)
						report_mismatch("address", result_address, e.addr);
					if (used_bytes != e.used)
						report_mismatch("used bytes", used_bytes, e.used);
				end
			end
		end
	end

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// Buddy allocator testbench
// Drives allocate and free requests into the buddy block allocator under
// several pool base addresses and idling patterns, starting with the size
// and address corner cases and going on to random alloc and free traffic
// that fills and fragments the pool. The checker beside the block predicts
// and compares every result; this module only makes stimulus and the verdict.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import bba_pkg::*;

	localparam int  POOL_BYTES = DEF_BLOCKS * DEF_MIN_BLOCK_BYTES;
	localparam int  RANDOM_PER_PHASE = 166;
	localparam int  SETTLE_CYCLES = 400;
	localparam int  CYCLE_LIMIT = 1_500_000;
	localparam logic CMD_FREE = 1'b1;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        command = CMD_ALLOC;
	logic [31:0] alloc_size = '0;
	logic [31:0] block_address = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [31:0] result_address;
	logic [20:0] used_bytes;
	int          errors;
	int          pending;

	int          send_idle_pct = 0;
	int          stall_pct = 0;
	logic        hold_go = 1'b0;
	int          hold_cnt = 0;
	int          cycles = 0;
	logic [31:0] cur_base = BASE_RESET;
	logic [31:0] live_offsets[$];
	logic        cmds_in_flight[$];

	always #6 clk = ~clk;

	buddy_block_allocator u_top (.*);

	bba_checker u_checker (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_go && hold_cnt == 0)
			hold_cnt <= 700;
		else if (hold_cnt > 0)
			hold_cnt <= hold_cnt - 1;
		out_stall <= (hold_cnt > 1) || ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (in_valid && !in_stall)
			cmds_in_flight.push_back(command);
		if (out_valid && !out_stall && cmds_in_flight.size() != 0) begin
			if (cmds_in_flight.pop_front() == CMD_ALLOC && status == STAT_OK)
				live_offsets.push_back(result_address - cur_base);
		end
	end

	task automatic send(logic cmd, logic [31:0] size, logic [31:0] addr);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		alloc_size <= size;
		block_address <= addr;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0 || cmds_in_flight.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_base(logic [31:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= '0;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cur_base = value;
	endtask

	function automatic logic [31:0] pick_size();
		int k;
		k = $urandom_range(99);
		if (k < 65)
			return $urandom_range(8192);
		if (k < 82)
			return $urandom_range(131072);
		if (k < 92)
			return $urandom_range(POOL_BYTES + 2048);
		if (k < 96)
			return DEF_MIN_BLOCK_BYTES << $urandom_range(10);
		return $urandom;
	endfunction

	task automatic free_live(bit random_in_block);
		int          i;
		logic [31:0] rel;
		i = $urandom_range(live_offsets.size() - 1);
		rel = live_offsets[i];
		live_offsets.delete(i);
		send(CMD_FREE, $urandom,
			cur_base + rel + (random_in_block ? $urandom_range(DEF_MIN_BLOCK_BYTES - 1) : 0));
	endtask

	task automatic random_traffic(int count);
		int k;
		for (int n = 0; n < count; n++) begin
			k = $urandom_range(99);
			if (live_offsets.size() != 0 && k < (live_offsets.size() > 40 ? 70 : 40))
				free_live($urandom_range(1));
			else if (k < 90)
				send(CMD_ALLOC, pick_size(), $urandom);
			else if (k < 93)
				send(CMD_FREE, $urandom, 32'd0);
			else if (k < 96)
				send(CMD_FREE, $urandom, $urandom);
			else
				send(CMD_FREE, $urandom, cur_base + $urandom_range(POOL_BYTES - 1));
		end
	endtask

	task automatic free_everything();
		drain();
		while (live_offsets.size() != 0)
			free_live(1'b1);
	endtask

	initial begin
		logic [31:0] bases[4];
		bases = '{32'h0000_0000, 32'hFFFF_FC00, 32'hFFFF_FFFF, 32'h0};
		bases[3] = $urandom;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(CMD_ALLOC, 32'd0, 32'hFFFF_FFFF);
		send(CMD_ALLOC, 32'd1, 32'd0);
		send(CMD_ALLOC, 32'd1025, $urandom);
		send(CMD_ALLOC, 32'hFFFF_FFFF, $urandom);
		send(CMD_ALLOC, POOL_BYTES + 1, $urandom);
		send(CMD_ALLOC, 32'd1024, $urandom);
		send(CMD_FREE, $urandom, 32'd0);
		send(CMD_FREE, $urandom, cur_base - 1);
		send(CMD_FREE, $urandom, cur_base + POOL_BYTES);
		send(CMD_FREE, 32'hFFFF_FFFF, cur_base + 32'h000C_0000);
		free_everything();
		send(CMD_ALLOC, POOL_BYTES, $urandom);
		send(CMD_ALLOC, 32'd0, $urandom);
		send(CMD_FREE, $urandom, cur_base + 5);
		send(CMD_ALLOC, POOL_BYTES / 2, $urandom);
		send(CMD_ALLOC, POOL_BYTES / 2, $urandom);
		send(CMD_ALLOC, 32'd1, $urandom);
		free_everything();
		send(CMD_FREE, $urandom, cur_base + 5);
		random_traffic(RANDOM_PER_PHASE);

		for (int ph = 0; ph < 4; ph++) begin
			free_everything();
			drain();
			write_base(bases[ph]);
			case (ph)
				0: begin send_idle_pct = 85; stall_pct = 0; end
				1: begin send_idle_pct = 0; stall_pct = 85; end
				2: begin send_idle_pct = 14; stall_pct = 14; end
				default: begin
					send_idle_pct = 0;
					stall_pct = 0;
					hold_go <= 1'b1;
				end
			endcase
			random_traffic(RANDOM_PER_PHASE);
			hold_go <= 1'b0;
		end

		drain();
		if (errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
